@@ design/ptsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsd_pkg
// Shared types for the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package ptsd_pkg;

    // Which point of the segment is nearest to the query point
    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_END   = 2'd1,
        MODE_PROJ  = 2'd2
    } t_seg_mode;

    localparam int MODE_W = 2;

    // Pipeline control handed to the iterative units
    typedef struct packed {
        logic en;     // whole pipeline advances
        logic valid;  // an item enters the unit
    } t_pipe_ctl;

endpackage

@@ design/ptsd_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsd_div
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den), num <= den.
// One quotient bit per stage, FRAC_BITS + 1 stages.
// ----------------------------------------------------------------------------
module ptsd_div import ptsd_pkg::*; #(
    parameter int NUM_BITS  = 49,
    parameter int FRAC_BITS = 24,
    parameter int SIDE_BITS = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_pipe_ctl            i_ctl,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [NUM_BITS-1:0]  i_den,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic                 o_valid,
    output logic [FRAC_BITS:0]   o_quot,
    output logic [SIDE_BITS-1:0] o_side
);

    localparam int STAGES = FRAC_BITS + 1;

    logic [STAGES-1:0]    r_vld;
    logic [NUM_BITS-1:0]  r_rem  [STAGES];
    logic [NUM_BITS-1:0]  r_den  [STAGES];
    logic [FRAC_BITS:0]   r_quot [STAGES];
    logic [SIDE_BITS-1:0] r_side [STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[STAGES-2:0], i_ctl.valid};
        end
    end

    // integer bit
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_num >= i_den) begin
                r_rem[0]  <= i_num - i_den;
                r_quot[0] <= {{FRAC_BITS{1'b0}}, 1'b1};
            end else begin
                r_rem[0]  <= i_num;
                r_quot[0] <= '0;
            end
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k < STAGES; k++) begin : g_stage
        logic [NUM_BITS:0] w_dbl;
        logic [NUM_BITS:0] w_diff;
        logic              w_ge;

        assign w_dbl  = {r_rem[k-1], 1'b0};
        assign w_diff = w_dbl - {1'b0, r_den[k-1]};
        assign w_ge   = (w_dbl >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k]  <= w_ge ? w_diff[NUM_BITS-1:0] : w_dbl[NUM_BITS-1:0];
                r_quot[k] <= {r_quot[k-1][FRAC_BITS-1:0], w_ge};
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_quot  = r_quot[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

@@ design/ptsd_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsd_sqrt
// Pipelined integer square root, floor(sqrt(rad)); one root bit per stage.
// ----------------------------------------------------------------------------
module ptsd_sqrt import ptsd_pkg::*; #(
    parameter int RAD_BITS  = 55,
    parameter int ROOT_BITS = 28
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_pipe_ctl            i_ctl,
    input  logic [RAD_BITS-1:0]  i_rad,
    output logic                 o_valid,
    output logic [ROOT_BITS-1:0] o_root
);

    localparam int NW = 2 * ROOT_BITS;
    localparam int RM = ROOT_BITS + 1;

    logic [ROOT_BITS-1:0] r_vld;
    logic [NW-1:0]        r_n    [ROOT_BITS];
    logic [RM-1:0]        r_rem  [ROOT_BITS];
    logic [ROOT_BITS-1:0] r_root [ROOT_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[ROOT_BITS-2:0], i_ctl.valid};
        end
    end

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        logic [NW-1:0]        w_n;
        logic [RM-1:0]        w_rem;
        logic [ROOT_BITS-1:0] w_root;
        logic [RM+1:0]        w_sh;
        logic [RM+1:0]        w_trial;
        logic [RM+1:0]        w_diff;
        logic                 w_ge;

        if (k == 0) begin : g_first
            assign w_n    = NW'(i_rad);
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_n    = r_n[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        assign w_sh    = {w_rem, w_n[NW-1 -: 2]};
        assign w_trial = {1'b0, w_root, 2'b01};
        assign w_ge    = (w_sh >= w_trial);
        assign w_diff  = w_sh - w_trial;

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_n[k]    <= {w_n[NW-3:0], 2'b00};
                r_rem[k]  <= w_ge ? w_diff[RM-1:0] : w_sh[RM-1:0];
                r_root[k] <= {w_root[ROOT_BITS-2:0], w_ge};
            end
        end
    end

    assign o_valid = r_vld[ROOT_BITS-1];
    assign o_root  = r_root[ROOT_BITS-1];

endmodule

@@ design/point_to_segment_distance_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_segment_distance_top
// Floor of the Euclidean distance from a query point to a line segment,
// signed fixed-point coordinates, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  s_axis   | in  | tdata: query_x, query_y, seg_start_x, seg_start_y,
//           |     |        seg_end_x, seg_end_y (COORD_BITS each, low first)
//  m_axis   | out | tdata: distance (COORD_BITS+1, zero padded)
//
//  One transfer per cycle in and out. The pipeline has 3 setup stages,
//  a divider of PARAM_FRAC_BITS + 1 stages, 7 offset stages, a square root
//  of COORD_BITS + 4 stages and the output register.
//  The whole pipeline moves together; it holds only when the output register
//  is full and the sink is not ready. Reset clears valid bits only.
// ----------------------------------------------------------------------------
module point_to_segment_distance_top import ptsd_pkg::*; #(
    parameter int COORD_BITS      = 24,
    parameter int PARAM_FRAC_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // query_x, query_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // distance
    output logic [((COORD_BITS+8)/8)*8-1:0]   o_m_axis_tdata
);

    localparam int CW    = COORD_BITS;
    localparam int FW    = PARAM_FRAC_BITS;
    localparam int DW    = CW + 1;          // coordinate differences
    localparam int PW    = 2 * DW;          // products of differences
    localparam int SW    = PW + 1;          // dot product
    localparam int LW    = 2 * CW + 1;      // squared length
    localparam int TW    = FW + 1;          // projection parameter U1.FW
    localparam int MW    = DW + 2;          // offset to nearest point
    localparam int QW    = 2 * MW + 1;      // squared offset
    localparam int RW    = MW + 1;          // square root
    localparam int OW    = CW + 1;          // distance
    localparam int OUT_W = ((CW + 8) / 8) * 8;
    localparam int SIDE  = MODE_W + 4 * DW;
    localparam logic [RW-1:0] DIST_MAX = RW'({OW{1'b1}});

    logic w_en;
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // ---------------- stage 1: differences ----------------
    logic [CW-1:0] w_qx, w_qy, w_sx, w_sy, w_ex, w_ey;
    assign w_qx = i_s_axis_tdata[0*CW +: CW];
    assign w_qy = i_s_axis_tdata[1*CW +: CW];
    assign w_sx = i_s_axis_tdata[2*CW +: CW];
    assign w_sy = i_s_axis_tdata[3*CW +: CW];
    assign w_ex = i_s_axis_tdata[4*CW +: CW];
    assign w_ey = i_s_axis_tdata[5*CW +: CW];

    logic                 r1_vld, r2_vld, r3_vld;
    logic signed [DW-1:0] r1_a, r1_b, r1_c, r1_d;
    logic signed [DW-1:0] r2_a, r2_b, r2_c, r2_d;
    logic signed [DW-1:0] r3_a, r3_b, r3_c, r3_d;
    logic signed [PW-1:0] r2_ac, r2_bd, r2_cc, r2_dd;
    logic signed [SW-1:0] r3_dot;
    logic [LW-1:0]        r3_len2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a <= $signed({w_qx[CW-1], w_qx}) - $signed({w_sx[CW-1], w_sx});
            r1_b <= $signed({w_qy[CW-1], w_qy}) - $signed({w_sy[CW-1], w_sy});
            r1_c <= $signed({w_ex[CW-1], w_ex}) - $signed({w_sx[CW-1], w_sx});
            r1_d <= $signed({w_ey[CW-1], w_ey}) - $signed({w_sy[CW-1], w_sy});
        end
    end

    // ---------------- stage 2: products ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ac <= r1_a * r1_c;
            r2_bd <= r1_b * r1_d;
            r2_cc <= r1_c * r1_c;
            r2_dd <= r1_d * r1_d;
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_c  <= r1_c;
            r2_d  <= r1_d;
        end
    end

    // ---------------- stage 3: dot and squared length ----------------
    logic signed [SW-1:0] w_len2_sum;
    assign w_len2_sum = SW'(r2_cc) + SW'(r2_dd);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_dot  <= SW'(r2_ac) + SW'(r2_bd);
            r3_len2 <= w_len2_sum[LW-1:0];
            r3_a    <= r2_a;
            r3_b    <= r2_b;
            r3_c    <= r2_c;
            r3_d    <= r2_d;
        end
    end

    // clamp: zero length or before the start, past the end, or a true projection
    t_seg_mode            w_mode;
    logic signed [SW-1:0] w_len2_ext;
    logic [LW-1:0]        w_num;
    assign w_len2_ext = $signed(SW'(r3_len2));

    always_comb begin
        if (r3_len2 == '0 || r3_dot < 0) begin
            w_mode = MODE_START;
        end else if (r3_dot > w_len2_ext) begin
            w_mode = MODE_END;
        end else begin
            w_mode = MODE_PROJ;
        end
    end

    assign w_num = (w_mode == MODE_PROJ) ? r3_dot[LW-1:0] : '0;

    // ---------------- divider ----------------
    t_pipe_ctl       w_div_ctl;
    logic            w_div_vld;
    logic [TW-1:0]   w_quot;
    logic [SIDE-1:0] w_dside;

    assign w_div_ctl = '{en: w_en, valid: r3_vld};

    ptsd_div #(
        .NUM_BITS  (LW),
        .FRAC_BITS (FW),
        .SIDE_BITS (SIDE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_num),
        .i_den   (r3_len2),
        .i_side  ({w_mode, r3_a, r3_b, r3_c, r3_d}),
        .o_valid (w_div_vld),
        .o_quot  (w_quot),
        .o_side  (w_dside)
    );

    t_seg_mode            w_dmode;
    logic signed [DW-1:0] w_da, w_db, w_dc, w_dd;
    assign w_dmode = t_seg_mode'(w_dside[SIDE-1 -: MODE_W]);
    assign w_da    = $signed(w_dside[3*DW +: DW]);
    assign w_db    = $signed(w_dside[2*DW +: DW]);
    assign w_dc    = $signed(w_dside[1*DW +: DW]);
    assign w_dd    = $signed(w_dside[0*DW +: DW]);

    // ---------------- P1: parameter select, magnitudes ----------------
    logic [TW-1:0]        n4_t;
    logic [TW-1:0]        r4_t;
    logic [DW-1:0]        r4_mc, r4_md;
    logic                 r4_nc, r4_nd;
    logic signed [DW-1:0] r4_a, r4_b;

    always_comb begin
        case (w_dmode)
            MODE_PROJ: n4_t = w_quot;
            MODE_END:  n4_t = {1'b1, {FW{1'b0}}};
            default:   n4_t = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_t  <= n4_t;
            r4_mc <= w_dc[DW-1] ? DW'(-w_dc) : DW'(w_dc);
            r4_md <= w_dd[DW-1] ? DW'(-w_dd) : DW'(w_dd);
            r4_nc <= w_dc[DW-1];
            r4_nd <= w_dd[DW-1];
            r4_a  <= w_da;
            r4_b  <= w_db;
        end
    end

    // ---------------- P2: t * |c| and t * |d| ----------------
    logic [TW+DW-1:0]     r5_pc, r5_pd;
    logic                 r5_nc, r5_nd;
    logic signed [DW-1:0] r5_a, r5_b;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_pc <= r4_t * r4_mc;
            r5_pd <= r4_t * r4_md;
            r5_nc <= r4_nc;
            r5_nd <= r4_nd;
            r5_a  <= r4_a;
            r5_b  <= r4_b;
        end
    end

    // ---------------- P3: floor of the scaled offset ----------------
    // negative c or d rounds the magnitude up so the signed result floors
    logic [DW:0]            w_qc, w_qd;
    logic signed [DW+1:0]   r6_sc, r6_sd;
    logic signed [DW-1:0]   r6_a, r6_b;

    assign w_qc = r5_pc[TW+DW-1:FW] + (DW+1)'(r5_nc && (r5_pc[FW-1:0] != '0));
    assign w_qd = r5_pd[TW+DW-1:FW] + (DW+1)'(r5_nd && (r5_pd[FW-1:0] != '0));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_sc <= r5_nc ? -$signed({1'b0, w_qc}) : $signed({1'b0, w_qc});
            r6_sd <= r5_nd ? -$signed({1'b0, w_qd}) : $signed({1'b0, w_qd});
            r6_a  <= r5_a;
            r6_b  <= r5_b;
        end
    end

    // ---------------- P4: offset ----------------
    logic signed [MW-1:0] r7_dx, r7_dy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_dx <= MW'(r6_a) - MW'(r6_sc);
            r7_dy <= MW'(r6_b) - MW'(r6_sd);
        end
    end

    // ---------------- P5: magnitude ----------------
    logic [MW-1:0] r8_mx, r8_my;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_mx <= r7_dx[MW-1] ? MW'(-r7_dx) : MW'(r7_dx);
            r8_my <= r7_dy[MW-1] ? MW'(-r7_dy) : MW'(r7_dy);
        end
    end

    // ---------------- P6: squares, P7: sum ----------------
    logic [2*MW-1:0] r9_sx, r9_sy;
    logic [QW-1:0]   r10_s2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_sx  <= r8_mx * r8_mx;
            r9_sy  <= r8_my * r8_my;
            r10_s2 <= QW'(r9_sx) + QW'(r9_sy);
        end
    end

    // valid bits of the local stages
    logic [6:0] r_pvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r_pvld <= '0;
        end else if (w_en) begin
            r1_vld <= i_s_axis_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r_pvld <= {r_pvld[5:0], w_div_vld};
        end
    end

    // ---------------- square root ----------------
    t_pipe_ctl     w_sq_ctl;
    logic          w_sq_vld;
    logic [RW-1:0] w_root;

    assign w_sq_ctl = '{en: w_en, valid: r_pvld[6]};

    ptsd_sqrt #(
        .RAD_BITS  (QW),
        .ROOT_BITS (RW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sq_ctl),
        .i_rad   (r10_s2),
        .o_valid (w_sq_vld),
        .o_root  (w_root)
    );

    // ---------------- output register, saturating ----------------
    logic          r_out_vld;
    logic [OW-1:0] r_out_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_dist <= (w_root > DIST_MAX) ? {OW{1'b1}} : w_root[OW-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_W'(r_out_dist);

    // ---------------- assertions ----------------
    // a zero-length segment always has a zero dot product
    a_zero_len_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_vld && r3_len2 == '0) |-> (r3_dot == '0))
        else $error("dot nonzero for zero-length segment");

    // a projection never runs past the end point
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_vld && w_dmode == MODE_PROJ) |-> (w_quot <= {1'b1, {FW{1'b0}}}))
        else $error("projection parameter above one");

    // a stalled pipeline takes no new item
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken during stall");

endmodule
